// ===== rtl/core/rsti_pkg.sv =====
package rsti_pkg;

    localparam int MAX_RADIX = 16;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 5;
    localparam int DIGIT_W = 4;
    localparam int ALPHA_W = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_WS_LO = 8'd9;   // tab
    localparam logic [CHAR_W-1:0] CHAR_WS_HI = 8'd13;  // carriage return

    // Classified byte, passed from front to back
    typedef struct packed {
        logic                is_term;
        logic                is_space;
        logic                is_plus;
        logic                is_minus;
        logic                is_digit;
        logic [DIGIT_W-1:0]  digit;
    } t_cmd;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [LEN_W-1:0] base_len;
        logic             base_ok;
    } t_view;

endpackage

// ===== rtl/core/radix_string_to_int.sv =====
// radix_string_to_int: parses a byte string into a signed 32-bit integer
// in a radix set by a configurable digit alphabet.
//
// Input side: push/full. One string byte per word on i_char_in; a zero
//   byte ends the string and produces exactly one result word.
// Result side: empty/pop. o_value (wrapped to 32 bits, 0 for a bad
//   alphabet) and o_base_ok are valid while o_empty is low.
// Config: i_cfg_we / i_cfg_index / i_cfg_data; 0 = base length,
//   1 = alphabet bytes 0-7, 2 = alphabet bytes 8-15. Write only when idle.
// Throughput: one byte per cycle, sustained while full is low. The front
//   end classifies a byte (16-way parallel digit compare) into a 2-deep
//   queue; the back end runs one multiply-add (32 x 5) per cycle on the
//   accumulator. A zero byte with nothing queued ahead is registered in
//   the cmd queue, then in the result queue, where o_empty goes low.
// Stall: if the receiver holds off pop, two results are buffered; a third
//   terminator waits in the queue and full rises once it is full.
// Reset (synchronous, active low) clears config, parser state and both
//   queues.
module radix_string_to_int (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rsti_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsti_pkg::ALPHA_W-1:0]         i_cfg_data,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic [rsti_pkg::CHAR_W-1:0]          i_char_in,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic signed [rsti_pkg::VALUE_W-1:0]  o_value,
    output logic                                 o_base_ok
);

    rsti_pkg::t_cmd  w_front_cmd;
    rsti_pkg::t_cmd  w_q_cmd;
    rsti_pkg::t_view w_view;
    logic            w_q_valid;
    logic            w_q_pop;

    // Front: config registers, alphabet check, byte classification
    rsti_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (i_char_in),
        .o_cmd       (w_front_cmd),
        .o_view      (w_view)
    );

    // Decoupling queue between classification and parsing
    rsti_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_cmd   (w_front_cmd),
        .o_full  (o_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Back: phase tracking, sign, accumulate, result buffer
    rsti_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .i_cmd     (w_q_cmd),
        .o_pop     (w_q_pop),
        .i_view    (w_view),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_value   (o_value),
        .o_base_ok (o_base_ok)
    );

endmodule

// ===== rtl/core/rsti_front.sv =====
module rsti_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rsti_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsti_pkg::ALPHA_W-1:0]         i_cfg_data,
    input  logic [rsti_pkg::CHAR_W-1:0]          i_char,
    output rsti_pkg::t_cmd                       o_cmd,
    output rsti_pkg::t_view                      o_view
);

    logic [rsti_pkg::LEN_W-1:0]     r_base_length;
    logic [rsti_pkg::ALPHA_W-1:0]   r_alpha_lo;
    logic [rsti_pkg::ALPHA_W-1:0]   r_alpha_hi;
    logic                           r_base_ok;
    logic                           n_base_ok;

    logic [2*rsti_pkg::ALPHA_W-1:0] w_alpha_all;
    logic [rsti_pkg::CHAR_W-1:0]    w_alpha [rsti_pkg::MAX_RADIX];
    logic [rsti_pkg::LEN_W-1:0]     w_len;
    logic [rsti_pkg::MAX_RADIX-1:0] w_match;
    logic [rsti_pkg::DIGIT_W-1:0]   w_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length <= '0;
            r_alpha_lo    <= '0;
            r_alpha_hi    <= '0;
            r_base_ok     <= 1'b0;
        end else begin
            r_base_ok <= n_base_ok;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rsti_pkg::REG_BASE_LENGTH:
                        r_base_length <= i_cfg_data[rsti_pkg::LEN_W-1:0];
                    rsti_pkg::REG_ALPHABET_LOW:  r_alpha_lo <= i_cfg_data;
                    rsti_pkg::REG_ALPHABET_HIGH: r_alpha_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign w_alpha_all = {r_alpha_hi, r_alpha_lo};

    always_comb begin
        for (int i = 0; i < rsti_pkg::MAX_RADIX; i++) begin
            w_alpha[i] = w_alpha_all[i*rsti_pkg::CHAR_W +: rsti_pkg::CHAR_W];
        end
    end

    // Digit lookup covers at most MAX_RADIX characters
    assign w_len = (r_base_length > rsti_pkg::LEN_W'(rsti_pkg::MAX_RADIX))
                   ? rsti_pkg::LEN_W'(rsti_pkg::MAX_RADIX) : r_base_length;

    // Alphabet check: length in range, no sign or NUL, no duplicates
    always_comb begin
        n_base_ok = (r_base_length >= rsti_pkg::LEN_W'(2)) &&
                    (r_base_length <= rsti_pkg::LEN_W'(rsti_pkg::MAX_RADIX));
        for (int a = 0; a < rsti_pkg::MAX_RADIX; a++) begin
            if (rsti_pkg::LEN_W'(a) < w_len) begin
                if (w_alpha[a] == rsti_pkg::CHAR_PLUS ||
                    w_alpha[a] == rsti_pkg::CHAR_MINUS ||
                    w_alpha[a] == rsti_pkg::CHAR_NUL) begin
                    n_base_ok = 1'b0;
                end
                for (int b = a + 1; b < rsti_pkg::MAX_RADIX; b++) begin
                    if (rsti_pkg::LEN_W'(b) < w_len && w_alpha[a] == w_alpha[b]) begin
                        n_base_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Parallel digit compare, lowest index wins
    always_comb begin
        w_digit = '0;
        for (int i = 0; i < rsti_pkg::MAX_RADIX; i++) begin
            w_match[i] = (rsti_pkg::LEN_W'(i) < w_len) && (i_char == w_alpha[i]);
        end
        for (int i = rsti_pkg::MAX_RADIX - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_digit = rsti_pkg::DIGIT_W'(i);
            end
        end
    end

    always_comb begin
        o_cmd.is_term  = (i_char == rsti_pkg::CHAR_NUL);
        o_cmd.is_space = (i_char == rsti_pkg::CHAR_SPACE) ||
                         (i_char >= rsti_pkg::CHAR_WS_LO && i_char <= rsti_pkg::CHAR_WS_HI);
        o_cmd.is_plus  = (i_char == rsti_pkg::CHAR_PLUS);
        o_cmd.is_minus = (i_char == rsti_pkg::CHAR_MINUS);
        o_cmd.is_digit = |w_match;
        o_cmd.digit    = w_digit;
    end

    assign o_view.base_len = r_base_length;
    assign o_view.base_ok  = r_base_ok;

endmodule

// ===== rtl/core/rsti_cmd_q.sv =====
module rsti_cmd_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsti_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rsti_pkg::t_cmd  o_cmd
);

    rsti_pkg::t_cmd r_slot [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/rsti_back.sv =====
module rsti_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  rsti_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    input  rsti_pkg::t_view                     i_view,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [rsti_pkg::VALUE_W-1:0] o_value,
    output logic                                o_base_ok
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGIT,
        PH_DONE
    } t_phase;

    t_phase                       r_phase, n_phase, w_ph;
    logic                         r_neg, n_neg;
    logic [rsti_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic [rsti_pkg::VALUE_W-1:0] w_mul;
    logic [rsti_pkg::VALUE_W-1:0] w_res;

    // two-entry result queue
    logic [rsti_pkg::VALUE_W-1:0] r_out_val [2];
    logic                         r_out_ok  [2];
    logic                         r_owptr;
    logic                         r_orptr;
    logic [1:0]                   r_ocnt;
    logic                         w_out_pop;
    logic                         w_out_room;
    logic                         w_res_push;

    assign o_empty    = (r_ocnt == 2'd0);
    assign w_out_pop  = i_pop && !o_empty;
    assign w_out_room = (r_ocnt != 2'd2) || w_out_pop;
    assign o_value    = r_out_val[r_orptr];
    assign o_base_ok  = r_out_ok[r_orptr];

    assign o_pop      = i_valid && (!i_cmd.is_term || w_out_room);
    assign w_res_push = o_pop && i_cmd.is_term;

    assign w_mul = rsti_pkg::VALUE_W'(r_acc * rsti_pkg::VALUE_W'(i_view.base_len));
    assign w_res = !i_view.base_ok ? '0 : (r_neg ? (~r_acc + 1'b1) : r_acc);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        w_ph    = r_phase;
        if (o_pop) begin
            if (i_cmd.is_term) begin
                n_phase = PH_SKIP;
                n_neg   = 1'b0;
                n_acc   = '0;
            end else begin
                if (w_ph == PH_SKIP && !i_cmd.is_space) begin
                    w_ph = PH_SIGN;
                end
                if (w_ph == PH_SIGN) begin
                    if (i_cmd.is_minus) begin
                        n_neg = ~r_neg;
                    end else if (!i_cmd.is_plus) begin
                        w_ph = PH_DIGIT;
                    end
                end
                if (w_ph == PH_DIGIT) begin
                    if (i_cmd.is_digit) begin
                        n_acc = w_mul + rsti_pkg::VALUE_W'(i_cmd.digit);
                    end else begin
                        w_ph = PH_DONE;
                    end
                end
                n_phase = w_ph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_owptr <= 1'b0;
            r_orptr <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            if (w_res_push) r_owptr <= ~r_owptr;
            if (w_out_pop)  r_orptr <= ~r_orptr;
            case ({w_res_push, w_out_pop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_out_val[r_owptr] <= w_res;
            r_out_ok[r_owptr]  <= i_view.base_ok;
        end
    end

endmodule

// ===== rtl/core/rsti_checker.sv =====
module rsti_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_full,
    input logic                                 o_empty,
    input logic                                 i_pop,
    input logic signed [rsti_pkg::VALUE_W-1:0]  o_value,
    input logic                                 o_base_ok
);

    // Both queues come out of reset empty
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    // A bad alphabet always reports zero
    a_bad_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_base_ok) |-> (o_value == '0))
        else $error("nonzero value with bad alphabet");

    // Waiting result holds while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_value) && $stable(o_base_ok)))
        else $error("result changed while stalled");

endmodule

bind radix_string_to_int rsti_checker u_rsti_checker (.*);

// ===== test/radix_string_to_int_test.sv =====
module radix_string_to_int_test;
    import rsti_pkg::*;

    localparam int HALF_PERIOD       = 6;
    localparam int RESET_CYCLES      = 6;
    localparam int SETTLE_CYCLES     = 4;
    localparam int STALL_CYCLES      = 160;    // long pop hold-off
    localparam int LIMIT_CYCLES      = 200000;
    localparam int STRINGS_PER_PHASE = 25;

    // index 3 is not decoded by the block; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        SCAN_SPACE,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_t;

    // flavors of digit alphabet the test loads
    typedef enum int {
        ALPHA_VALID,
        ALPHA_MIN,
        ALPHA_MAX,
        ALPHA_TOO_SHORT,
        ALPHA_TOO_LONG,
        ALPHA_PLUS,
        ALPHA_MINUS,
        ALPHA_NUL,
        ALPHA_REPEAT
    } alphabet_kind_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               base_ok;
    } parse_result_t;

    // ---------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [ALPHA_W-1:0]         i_cfg_data  = '0;
    logic                       i_push      = 1'b0;
    logic [CHAR_W-1:0]          i_char_in   = '0;
    logic                       i_pop       = 1'b0;
    logic                       o_full;
    logic                       o_empty;
    logic signed [VALUE_W-1:0]  o_value;
    logic                       o_base_ok;

    always #HALF_PERIOD i_clk = ~i_clk;

    radix_string_to_int dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_char_in   (i_char_in),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_value     (o_value),
        .o_base_ok   (o_base_ok)
    );

    // ---------------------------------------------------------------
    // Parser mirror: config copy and scan state, updated on every
    // accepted word. Results land in parsed_values, oldest first.
    // ---------------------------------------------------------------
    logic [LEN_W-1:0]     base_len   = '0;
    logic [2*ALPHA_W-1:0] glyphs     = '0;   // digit i in bits [8i +: 8]
    scan_phase_t          scan_phase = SCAN_SPACE;
    logic                 minus_odd  = 1'b0;
    logic [VALUE_W-1:0]   magnitude  = '0;
    parse_result_t        parsed_values[$];

    logic [CHAR_W-1:0]    string_bytes[$];   // string being built for sending

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int stalls_asked  = 0;
    int stalls_taken  = 0;
    int stall_left    = 0;
    int mismatches    = 0;

    function automatic logic [CHAR_W-1:0] glyph_at(input int idx);
        return glyphs[idx*8 +: 8];
    endfunction

    // radix 2..16, no sign or NUL among the digits, no digit twice
    function automatic bit alphabet_valid();
        int a, b;
        logic [CHAR_W-1:0] ca;
        if (base_len < 2 || base_len > MAX_RADIX)
            return 1'b0;
        for (a = 0; a < base_len; a++) begin
            ca = glyph_at(a);
            if (ca == CHAR_PLUS || ca == CHAR_MINUS || ca == CHAR_NUL)
                return 1'b0;
            for (b = a + 1; b < base_len; b++)
                if (glyph_at(b) == ca)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // lowest matching digit index, -1 when the byte is not a digit
    function automatic int digit_index(input logic [CHAR_W-1:0] c);
        int i, span;
        span = (base_len > 16) ? 16 : base_len;
        for (i = 0; i < span; i++)
            if (glyph_at(i) == c)
                return i;
        return -1;
    endfunction

    function automatic void parse_byte(input logic [CHAR_W-1:0] c);
        parse_result_t r;
        int d;
        if (c == CHAR_NUL) begin
            r.base_ok = alphabet_valid();
            r.value   = minus_odd ? -magnitude : magnitude;
            if (!r.base_ok)
                r.value = '0;
            parsed_values.push_back(r);
            scan_phase = SCAN_SPACE;
            minus_odd  = 1'b0;
            magnitude  = '0;
            return;
        end
        if (scan_phase == SCAN_SPACE) begin
            if (c == CHAR_SPACE || (c >= CHAR_WS_LO && c <= CHAR_WS_HI))
                return;
            scan_phase = SCAN_SIGN;
        end
        if (scan_phase == SCAN_SIGN) begin
            if (c == CHAR_PLUS)
                return;
            if (c == CHAR_MINUS) begin
                minus_odd = ~minus_odd;
                return;
            end
            scan_phase = SCAN_DIGITS;
        end
        if (scan_phase == SCAN_DIGITS) begin
            d = digit_index(c);
            if (d < 0)
                scan_phase = SCAN_DONE;
            else
                magnitude = magnitude * base_len + d;   // wraps at 32 bits
        end
    endfunction

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    // random digit of the loaded alphabet, or any nonzero byte if it is empty
    function automatic logic [CHAR_W-1:0] pick_glyph();
        int span;
        span = (base_len > 16) ? 16 : base_len;
        if (span == 0)
            return 8'($urandom_range(1, 255));
        return glyph_at($urandom_range(span - 1));
    endfunction

    // 16 distinct bytes, none of them NUL or a sign
    function automatic logic [2*ALPHA_W-1:0] distinct_glyphs();
        bit [255:0] taken;
        logic [CHAR_W-1:0] c;
        logic [2*ALPHA_W-1:0] g;
        int i;
        taken = '0;
        taken[CHAR_NUL]   = 1'b1;
        taken[CHAR_PLUS]  = 1'b1;
        taken[CHAR_MINUS] = 1'b1;
        for (i = 0; i < 16; i++) begin
            do
                c = 8'($urandom_range(255));
            while (taken[c]);
            taken[c] = 1'b1;
            g[i*8 +: 8] = c;
        end
        return g;
    endfunction

    // ---------------------------------------------------------------
    // Sender: all driving at the falling edge. A task returns at a
    // falling edge with push still high, so back-to-back words never
    // drop push in between.
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push    <= 1'b0;
            i_char_in <= 8'($urandom);
            @(negedge i_clk);
        end
        i_push    <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        parse_byte(c);
        @(negedge i_clk);
    endtask

    task automatic send_terminated();
        string_bytes.push_back(CHAR_NUL);
        while (string_bytes.size() != 0)
            send_byte(string_bytes.pop_front());
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            string_bytes.push_back(s[i]);
    endtask

    // stop offering words, let every result out, then let the pipe settle
    task automatic wait_idle();
        i_push <= 1'b0;
        while (parsed_values.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Config writes, only issued from an idle block
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        case (idx)
            REG_BASE_LENGTH:   base_len = data[LEN_W-1:0];
            REG_ALPHABET_LOW:  glyphs[ALPHA_W-1:0] = data;
            REG_ALPHABET_HIGH: glyphs[2*ALPHA_W-1:ALPHA_W] = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] len_word, input logic [63:0] lo,
                             input logic [63:0] hi);
        wait_idle();
        write_reg(REG_BASE_LENGTH, len_word);
        write_reg(REG_ALPHABET_LOW, lo);
        write_reg(REG_ALPHABET_HIGH, hi);
        write_reg(REG_SPARE, random64());
        i_cfg_we <= 1'b0;
    endtask

    // extreme picks the outermost bad lengths (0 and 31)
    task automatic apply_alphabet(input alphabet_kind_t kind, input bit extreme);
        logic [2*ALPHA_W-1:0] g;
        logic [63:0] len_word;
        int len, pos, other;
        g   = distinct_glyphs();
        len = $urandom_range(2, 16);
        pos = $urandom_range(0, len - 1);
        case (kind)
            ALPHA_MIN:       len = 2;
            ALPHA_MAX:       len = 16;
            ALPHA_TOO_SHORT: len = extreme ? 0 : $urandom_range(1);
            ALPHA_TOO_LONG:  len = extreme ? 31 : $urandom_range(17, 31);
            ALPHA_PLUS:      g[pos*8 +: 8] = CHAR_PLUS;
            ALPHA_MINUS:     g[pos*8 +: 8] = CHAR_MINUS;
            ALPHA_NUL:       g[pos*8 +: 8] = CHAR_NUL;
            ALPHA_REPEAT: begin
                pos   = $urandom_range(1, len - 1);
                other = $urandom_range(0, pos - 1);
                g[pos*8 +: 8] = g[other*8 +: 8];
            end
            default: ;
        endcase
        // junk in the unused upper bits of the length word
        len_word = random64();
        len_word[LEN_W-1:0] = len[LEN_W-1:0];
        configure(len_word, g[ALPHA_W-1:0], g[2*ALPHA_W-1:ALPHA_W]);
    endtask

    // Mostly well formed: blanks, sign run, digits, maybe trailing junk.
    // The rest is noise mixing junk, digits, signs and blanks.
    task automatic send_random_string();
        int n, k;
        if ($urandom_range(99) < 80) begin
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                string_bytes.push_back($urandom_range(1) ? CHAR_SPACE
                                                         : 8'($urandom_range(9, 13)));
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                string_bytes.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
            // long runs push the accumulator past 32 bits
            n = ($urandom_range(5) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9);
            for (k = 0; k < n; k++)
                string_bytes.push_back(pick_glyph());
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                    string_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end else begin
            n = $urandom_range(0, 8);
            for (k = 0; k < n; k++)
                case ($urandom_range(3))
                    0, 1: string_bytes.push_back(8'($urandom_range(1, 255)));
                    2:    string_bytes.push_back(pick_glyph());
                    default:
                        case ($urandom_range(2))
                            0:       string_bytes.push_back(CHAR_MINUS);
                            1:       string_bytes.push_back(CHAR_PLUS);
                            default: string_bytes.push_back(CHAR_SPACE);
                        endcase
                endcase
        end
        send_terminated();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // decimal alphabet; parse phases and their edges
    task automatic test_directed();
        int c;
        configure(64'd10, "76543210", {48'hFFFF_FFFF_FFFF, "98"});
        // every blank code, odd minus count in a mixed sign run, a stop
        // byte, then a digit that must be ignored
        for (c = CHAR_WS_LO; c <= CHAR_WS_HI; c++)
            string_bytes.push_back(8'(c));
        queue_text(" -+--42x7");
        send_terminated();
        send_terminated();                  // empty string
        queue_text("-");                    // negated zero
        send_terminated();
        string_bytes.push_back(8'd14);      // just above the blank range
        queue_text("5");
        send_terminated();
        queue_text("- 5");                  // blank after the sign stops it
        send_terminated();
    endtask

    // one load per alphabet flavor, extremes of the bad lengths included
    task automatic test_alphabet_checks();
        int k;
        for (k = ALPHA_VALID; k <= ALPHA_REPEAT; k++) begin
            apply_alphabet(alphabet_kind_t'(k), 1'b1);
            string_bytes.push_back(glyph_at(1));
            send_terminated();
        end
    endtask

    task automatic test_random(input int n_strings);
        int k, kind_n;
        for (k = 0; k < n_strings; k++) begin
            if (k % 6 == 0) begin
                kind_n = $urandom_range(0, 17);
                if (kind_n > ALPHA_REPEAT)
                    kind_n = ALPHA_VALID;
                apply_alphabet(alphabet_kind_t'(kind_n), $urandom_range(1));
            end
            send_random_string();
        end
    endtask

    // pop is held off long enough for the result buffer and the input
    // queue to fill, so full must rise; afterwards the sender waits for
    // the backlog to clear before it goes on
    task automatic test_backpressure();
        int k;
        apply_alphabet(ALPHA_MAX, 1'b0);
        stalls_asked++;
        for (k = 0; k < 12; k++) begin
            if (k % 2 == 1)
                string_bytes.push_back(CHAR_MINUS);
            string_bytes.push_back(pick_glyph());
            string_bytes.push_back(pick_glyph());
            send_terminated();
        end
        wait_idle();
        for (k = 0; k < 4; k++)
            send_random_string();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        take_idle_pct = 79;
        test_directed();
        test_alphabet_checks();
        test_random(STRINGS_PER_PHASE);

        send_idle_pct = 79;
        take_idle_pct = 34;
        test_random(STRINGS_PER_PHASE);

        send_idle_pct = 0;
        take_idle_pct = 0;
        test_backpressure();
        test_random(STRINGS_PER_PHASE);

        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: pop decided at the falling edge. A stall request holds
    // pop low until its countdown in stall_left runs out.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_pop <= 1'b0;
        end else if (stalls_taken < stalls_asked) begin
            stalls_taken++;
            stall_left = STALL_CYCLES - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= i_rst_n && ($urandom_range(99) >= take_idle_pct);
        end
    end

    // result words taken at the rising edge, checked against the oldest
    // pending parse
    always @(posedge i_clk) begin : check_results
        parse_result_t want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (parsed_values.size() == 0) begin
                $error("result word with no string pending: value %0d, base_ok %0b",
                       o_value, o_base_ok);
                mismatches++;
            end else begin
                want = parsed_values.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", $signed(want.value), o_value);
                    mismatches++;
                end
                if (o_base_ok !== want.base_ok) begin
                    $error("base_ok: expected %0b, got %0b", want.base_ok, o_base_ok);
                    mismatches++;
                end
            end
        end
    end

    // hang guard
    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

endmodule
